FILE: rtl/chx_pkg.sv
`default_nettype none

package chx_pkg;

    localparam int XY_W   = 42;
    localparam int Z_W    = 20;
    localparam int DIR_W  = 17;
    localparam int DEG_W  = 16;
    localparam int PROD_W = 42;
    localparam int MAX_STAGES = 24;
    localparam int SCALE_SHIFT = 24;

    localparam logic signed [Z_W-1:0] ANGLE_PI = 20'sd205887;
    localparam logic signed [17:0] DIR_LIMIT = 18'sd51472;
    localparam logic signed [17:0] DEG_FULL = 18'sd46080;
    localparam logic signed [24:0] DEG_COEF = 25'sd15019745;
    localparam logic signed [PROD_W-1:0] DEG_ROUND = PROD_W'(64'sd8388608);

    localparam logic signed [Z_W-1:0] ATAN_TAB [MAX_STAGES] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150,
        20'sd4091,  20'sd2047,  20'sd1024,  20'sd512,
        20'sd256,   20'sd128,   20'sd64,    20'sd32,
        20'sd16,    20'sd8,     20'sd4,     20'sd2,
        20'sd1,     20'sd0,     20'sd0,     20'sd0,
        20'sd0,     20'sd0,     20'sd0,     20'sd0
    };

    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

endpackage

`default_nettype wire

FILE: rtl/chx_cordic_stage.sv
`default_nettype none

module chx_cordic_stage
    import chx_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_cordic i_stage,
    output t_cordic      o_stage
);

    t_cordic r_stage;
    t_cordic n_stage;

    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;

    always_comb begin
        w_xs = i_stage.x >>> SHIFT;
        w_ys = i_stage.y >>> SHIFT;
        n_stage = i_stage;
        if (i_stage.y >= 0) begin
            n_stage.x = i_stage.x + w_ys;
            n_stage.y = i_stage.y - w_xs;
            n_stage.z = i_stage.z + ATAN_TAB[SHIFT];
        end else begin
            n_stage.x = i_stage.x - w_ys;
            n_stage.y = i_stage.y + w_xs;
            n_stage.z = i_stage.z - ATAN_TAB[SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

FILE: rtl/compass_heading_from_xy.sv
// Compass heading from one magnetometer X/Y sample pair.
// A transaction is accepted at a rising edge with i_start high; o_busy is always
// low, so a new sample pair can be given in every cycle.
// The result appears on o_direction_rad and o_heading_deg for exactly one cycle,
// marked by o_strobe, once the transaction has passed every pipeline stage named
// below. Throughput is one transaction per cycle.
// The pipeline is one input stage (quadrant fold and scaling), one register per
// CORDIC iteration, one stage for rounding, declination add and saturation, one
// for the degree multiply and one for rounding and wrapping into 0 to 360 degrees.
// The declination register is written through i_cfg_valid / o_cfg_ready /
// i_cfg_data and should only change while no transaction is in flight.
// Reset clears the declination to zero and drops every transaction in flight.
// The receiver cannot stall, so no result is ever held back.
`default_nettype none

module compass_heading_from_xy
    import chx_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    output logic                     o_busy,
    input  wire  signed [15:0]       i_field_x,
    input  wire  signed [15:0]       i_field_y,
    output logic                     o_strobe,
    output logic signed [DIR_W-1:0]  o_direction_rad,
    output logic        [DEG_W-1:0]  o_heading_deg,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  signed [15:0]       i_cfg_data
);

    localparam int LATENCY = CORDIC_STAGES + 4;

    logic signed [15:0] r_decl;

    t_cordic w_stage [0:CORDIC_STAGES];
    t_cordic r_in;
    t_cordic n_in;

    logic signed [16:0] w_xa;
    logic signed [16:0] w_ya;

    logic                     r_dir_valid;
    logic signed [DIR_W-1:0]  r_dir;
    logic signed [DIR_W-1:0]  n_dir;
    logic signed [Z_W-1:0]    w_z;
    logic signed [Z_W-1:0]    w_zr;
    logic signed [17:0]       w_dir_raw;

    logic                     r_prod_valid;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_prod_rnd;
    logic signed [17:0]       w_deg;
    logic signed [17:0]       w_deg_wrap;
    logic        [DEG_W-1:0]  n_deg;

    logic                     r_out_valid;
    logic signed [DIR_W-1:0]  r_out_dir;
    logic signed [DIR_W-1:0]  r_mul_dir;
    logic        [DEG_W-1:0]  r_out_deg;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_decl <= i_cfg_data;
        end
    end

    // Fold the left half plane onto the right one and scale to exact integers.
    always_comb begin
        n_in       = '0;
        n_in.valid = i_start && !o_busy;
        n_in.zero  = (i_field_x == 16'sd0) && (i_field_y == 16'sd0);
        if (i_field_x < 0) begin
            w_xa   = -17'(i_field_x);
            w_ya   = -17'(i_field_y);
            n_in.z = (i_field_y >= 0) ? ANGLE_PI : -ANGLE_PI;
        end else begin
            w_xa   = 17'(i_field_x);
            w_ya   = 17'(i_field_y);
            n_in.z = '0;
        end
        n_in.x = XY_W'(w_xa) <<< SCALE_SHIFT;
        n_in.y = XY_W'(w_ya) <<< SCALE_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in <= n_in;
        end
    end

    assign w_stage[0] = r_in;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        chx_cordic_stage #(
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    // Round the angle to 13 fraction bits, add the declination and saturate.
    always_comb begin
        w_z       = w_stage[CORDIC_STAGES].zero ? '0 : w_stage[CORDIC_STAGES].z;
        w_zr      = (w_z + Z_W'(4)) >>> 3;
        w_dir_raw = 18'(w_zr) + 18'(r_decl);
        if (w_dir_raw > DIR_LIMIT) begin
            n_dir = DIR_W'(DIR_LIMIT);
        end else if (w_dir_raw < -DIR_LIMIT) begin
            n_dir = DIR_W'(-DIR_LIMIT);
        end else begin
            n_dir = DIR_W'(w_dir_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_valid <= 1'b0;
        end else begin
            r_dir_valid <= w_stage[CORDIC_STAGES].valid;
        end
        r_dir <= n_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= r_dir_valid;
        end
        r_prod    <= PROD_W'(r_dir) * PROD_W'(DEG_COEF);
        r_mul_dir <= r_dir;
    end

    // Round to 7 fraction bits of degrees and wrap negative angles once.
    always_comb begin
        w_prod_rnd = r_prod + DEG_ROUND;
        w_deg      = w_prod_rnd[PROD_W-1:SCALE_SHIFT];
        w_deg_wrap = (w_deg < 0) ? w_deg + DEG_FULL : w_deg;
        if (w_deg_wrap < 0) begin
            n_deg = '0;
        end else if (w_deg_wrap > DEG_FULL) begin
            n_deg = DEG_W'(DEG_FULL);
        end else begin
            n_deg = DEG_W'(w_deg_wrap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_prod_valid;
        end
        r_out_dir <= r_mul_dir;
        r_out_deg <= n_deg;
    end

    assign o_strobe        = r_out_valid;
    assign o_direction_rad = r_out_dir;
    assign o_heading_deg   = r_out_deg;

    a_strobe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start, LATENCY))
        else $error("result strobe without a matching accepted transaction");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (18'(o_heading_deg) <= DEG_FULL))
        else $error("heading outside 0 to 360 degrees");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (18'(o_direction_rad) <= DIR_LIMIT && 18'(o_direction_rad) >= -DIR_LIMIT))
        else $error("direction outside its saturation limits");

endmodule

`default_nettype wire

FILE: dv/compass_heading_from_xy_tb.sv
`timescale 1ns / 1ps

module compass_heading_from_xy_tb;
    import chx_pkg::*;

    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = CORDIC_STAGES + 4;
    localparam int DEG_SHIFT     = 24;
    localparam int ROUND_BITS    = 3;
    localparam int GAP_MAX       = 15;
    localparam int PHASE_ITEMS   = 140;
    localparam int PHASE_COUNT   = 5;
    localparam int PRINT_LIMIT   = 20;

    localparam logic signed [15:0] FIELD_MAX = 16'sh7FFF;
    localparam logic signed [15:0] FIELD_MIN = 16'sh8000;
    localparam logic signed [15:0] DECL_HIGH = 16'sd25736;
    localparam logic signed [15:0] DECL_LOW  = -16'sd25736;

    typedef struct {
        logic signed [15:0]      fx;
        logic signed [15:0]      fy;
        logic signed [DIR_W-1:0] dir;
        logic        [DEG_W-1:0] deg;
    } t_heading;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_start = 1'b0;
    logic signed [15:0]      i_field_x = '0;
    logic signed [15:0]      i_field_y = '0;
    logic                    i_cfg_valid = 1'b0;
    logic signed [15:0]      i_cfg_data = '0;
    logic                    o_busy;
    logic                    o_strobe;
    logic signed [DIR_W-1:0] o_direction_rad;
    logic        [DEG_W-1:0] o_heading_deg;
    logic                    o_cfg_ready;

    t_heading           heading_q[$];
    logic signed [15:0] declination = '0;
    int                 error_count = 0;
    int                 samples_sent = 0;
    int                 headings_checked = 0;
    int                 decl_writes = 0;
    logic               no_gaps = 1'b0;

    compass_heading_from_xy #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_field_x       (i_field_x),
        .i_field_y       (i_field_y),
        .o_strobe        (o_strobe),
        .o_direction_rad (o_direction_rad),
        .o_heading_deg   (o_heading_deg),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", heading_q.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic t_heading predict_heading(input logic signed [15:0] fx,
                                                 input logic signed [15:0] fy,
                                                 input logic signed [15:0] decl);
        longint   xa;
        longint   ya;
        longint   za;
        longint   xs;
        longint   ys;
        longint   dir;
        longint   deg;
        t_heading r;
        xa = fx;
        ya = fy;
        za = 0;
        if (xa != 0 || ya != 0) begin
            if (xa < 0) begin
                za = longint'(ANGLE_PI);
                if (ya < 0) begin
                    za = -za;
                end
                xa = -xa;
                ya = -ya;
            end
            xa = xa <<< SCALE_SHIFT;
            ya = ya <<< SCALE_SHIFT;
            for (int i = 0; i < CORDIC_STAGES && i < MAX_STAGES; i++) begin
                xs = xa >>> i;
                ys = ya >>> i;
                if (ya >= 0) begin
                    xa = xa + ys;
                    ya = ya - xs;
                    za = za + longint'(ATAN_TAB[i]);
                end else begin
                    xa = xa - ys;
                    ya = ya + xs;
                    za = za - longint'(ATAN_TAB[i]);
                end
            end
        end
        dir = ((za + 4) >>> ROUND_BITS) + longint'(decl);
        if (dir > longint'(DIR_LIMIT)) begin
            dir = longint'(DIR_LIMIT);
        end
        if (dir < -longint'(DIR_LIMIT)) begin
            dir = -longint'(DIR_LIMIT);
        end
        deg = (dir * longint'(DEG_COEF) + longint'(DEG_ROUND)) >>> DEG_SHIFT;
        if (deg < 0) begin
            deg = deg + longint'(DEG_FULL);
        end
        if (deg < 0) begin
            deg = 0;
        end
        if (deg > longint'(DEG_FULL)) begin
            deg = longint'(DEG_FULL);
        end
        r.fx  = fx;
        r.fy  = fy;
        r.dir = dir[DIR_W-1:0];
        r.deg = deg[DEG_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_heading exp_h;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (heading_q.size() == 0) begin
                    report_mismatch("Result with no transaction pending");
                end else begin
                    exp_h = heading_q.pop_front();
                    headings_checked++;
                    if (o_direction_rad !== exp_h.dir) begin
                        report_mismatch($sformatf("x=%0d y=%0d direction %0d, expected %0d",
                            exp_h.fx, exp_h.fy, o_direction_rad, exp_h.dir));
                    end
                    if (o_heading_deg !== exp_h.deg) begin
                        report_mismatch($sformatf("x=%0d y=%0d heading %0d, expected %0d",
                            exp_h.fx, exp_h.fy, o_heading_deg, exp_h.deg));
                    end
                end
            end
            if (i_start && !o_busy) begin
                heading_q.push_back(predict_heading(i_field_x, i_field_y, declination));
                samples_sent++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                declination = i_cfg_data;
                decl_writes++;
            end
        end
    end

    task automatic send_sample(input logic signed [15:0] fx, input logic signed [15:0] fy);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
        repeat (gap) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start   <= 1'b1;
        i_field_x <= fx;
        i_field_y <= fy;
        do begin
            @(posedge i_clk);
        end while (o_busy);
    endtask

    task automatic drain_pipeline();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (heading_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_declination(input logic signed [15:0] value);
        drain_pipeline();
        repeat (LATENCY) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_axes_and_corners();
        no_gaps = 1'b0;
        send_sample(16'sd0, 16'sd0);
        send_sample(FIELD_MAX, 16'sd0);
        send_sample(FIELD_MIN, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd0, FIELD_MAX);
        send_sample(16'sd0, FIELD_MIN);
        send_sample(FIELD_MAX, FIELD_MAX);
        send_sample(FIELD_MIN, FIELD_MIN);
        send_sample(FIELD_MIN, FIELD_MAX);
        send_sample(FIELD_MAX, FIELD_MIN);
        no_gaps = 1'b1;
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd1);
        send_sample(16'sd0, -16'sd1);
        send_sample(-16'sd1, -16'sd1);
        send_sample(-16'sd1, 16'sd1);
        send_sample(16'sd1, -16'sd1);
        send_sample(FIELD_MIN, -16'sd1);
        send_sample(FIELD_MIN, 16'sd1);
        no_gaps = 1'b0;
    endtask

    task automatic test_declination_limits();
        logic signed [15:0] decl_set[4];
        decl_set = '{DECL_HIGH, DECL_LOW, FIELD_MAX, FIELD_MIN};
        foreach (decl_set[k]) begin
            write_declination(decl_set[k]);
            send_sample(16'sd0, 16'sd0);
            send_sample(FIELD_MIN, 16'sd0);
            send_sample(FIELD_MIN, -16'sd1);
            send_sample(16'sd0, FIELD_MIN);
        end
    endtask

    task automatic test_random_samples();
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] decl;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: decl = 16'sd0;
                1: decl = DECL_HIGH;
                2: decl = DECL_LOW;
                default: decl = 16'($urandom_range(0, 2 * DECL_HIGH) - DECL_HIGH);
            endcase
            write_declination(decl);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 35 == 0) begin
                    no_gaps = ($urandom_range(0, 2) == 0);
                end
                if (p == 2 && n == PHASE_ITEMS / 2) begin
                    drain_pipeline();
                end
                fx = 16'($urandom());
                fy = 16'($urandom());
                case ($urandom_range(0, 7))
                    0: begin
                        fx = 16'($urandom_range(0, 8)) - 16'sd4;
                        fy = 16'($urandom_range(0, 8)) - 16'sd4;
                    end
                    1: fy = fx;
                    2: fy = -fx;
                    3: fx = 16'sd0;
                    4: fy = 16'sd0;
                    5: fx = ($urandom_range(0, 1) != 0) ? FIELD_MAX : FIELD_MIN;
                    default: ;
                endcase
                send_sample(fx, fy);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_axes_and_corners();
        test_declination_limits();
        test_random_samples();
        drain_pipeline();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Run covered %0d sample pairs and %0d checked results",
            samples_sent, headings_checked);
        $display("over %0d declination writes, with axes, corners, zero and saturation.",
            decl_writes);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
